[src/mbs_pkg.sv]
package mbs_pkg;

    localparam int RAND_W    = 16;
    localparam int BIAS_W    = 4;
    localparam int LEN_W     = 6;
    localparam int WALL_W    = 4;
    localparam int COL_OUT_W = 5;
    localparam int ROW_OUT_W = 5;

    localparam logic [WALL_W-1:0] ALL_WALLS = 4'hF;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic {
        REG_HBIAS = 1'b0,
        REG_VBIAS = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LAST,
        S_MOD,
        S_WCUR,
        S_WNEXT,
        S_POP,
        S_PRD,
        S_PCAP,
        S_OUT
    } state_t;

    // wall on the current cell crossed when moving in direction d
    function automatic logic [WALL_W-1:0] own_bit(dir_t d);
        logic [WALL_W-1:0] b;
        case (d)
            DIR_RIGHT: b = 4'b0010;
            DIR_LEFT:  b = 4'b1000;
            DIR_DOWN:  b = 4'b0100;
            DIR_UP:    b = 4'b0001;
            default:   b = 4'b0000;
        endcase
        return b;
    endfunction

    // matching wall on the neighbour
    function automatic logic [WALL_W-1:0] far_bit(dir_t d);
        logic [WALL_W-1:0] b;
        case (d)
            DIR_RIGHT: b = 4'b1000;
            DIR_LEFT:  b = 4'b0010;
            DIR_DOWN:  b = 4'b0001;
            DIR_UP:    b = 4'b0100;
            default:   b = 4'b0000;
        endcase
        return b;
    endfunction

endpackage

[src/maze_backtracker_step.sv]
// Maze generator by recursive backtracking, one walk step per input word.
// Input channel (in_valid/in_ready): command 0 takes one step from the
// current cell, command 1 restarts with a fresh grid. random_value picks
// among the unvisited neighbours, weighted by the two bias registers.
// Output channel (out_valid/out_ready): one word per input word giving the
// cell after the step, carve or backtrack flags, its walls and maze_done.
// Configuration: cfg_write_en writes cfg_data into horizontal (index 0) or
// vertical (index 1) bias at once; write only while the block is idle.
// A step word passes through five cell memory reads, a restoring modulo over
// the 16 bits of random_value (one shared subtractor), the write-back and,
// on a pop, a stack read and a cell read. A restart word goes straight to
// the output register.
// One word is in flight at a time; in_ready is high only while idle, so a
// new step word is taken only after the last result is loaded for output.
// Reset, restart and a finished maze each start a clearing pass over all
// GRID_WIDTH*GRID_HEIGHT cells (768 by default) that rewrites every cell;
// no input word is taken during it.
// A stalled receiver holds the result in the output register; the next
// word may already be taken and worked on, and waits at its end.
module maze_backtracker_step #(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  mbs_pkg::reg_idx_t                      cfg_index,
    input  logic [mbs_pkg::BIAS_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   command,
    input  logic [mbs_pkg::RAND_W-1:0]             random_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mbs_pkg::COL_OUT_W-1:0]          cell_col,
    output logic [mbs_pkg::ROW_OUT_W-1:0]          cell_row,
    output logic                                   carved,
    output logic [1:0]                             carve_direction,
    output logic                                   backtracking,
    output logic [mbs_pkg::WALL_W-1:0]             cell_walls,
    output logic                                   maze_done
);
    import mbs_pkg::*;

    localparam int CW    = $clog2(GRID_WIDTH);
    localparam int RW    = $clog2(GRID_HEIGHT);
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);

    state_t state_reg, state_next;
    logic [BIAS_W-1:0] hbias_reg, hbias_next, vbias_reg, vbias_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          out_valid_reg, out_valid_next;

    logic [RAND_W-1:0] rnd_reg, rnd_next;
    logic [2:0]        rd_cnt_reg, rd_cnt_next;
    logic [WALL_W-1:0] cur_wall_reg, cur_wall_next;
    logic [3:0]        nb_vis_reg, nb_vis_next;
    logic [WALL_W-1:0] nb_wall_reg [4];
    logic [WALL_W-1:0] nb_wall_next [4];
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [3:0]        bit_cnt_reg, bit_cnt_next;
    logic              res_carved_reg, res_carved_next;
    dir_t              res_dir_reg, res_dir_next;
    logic              res_back_reg, res_back_next;
    logic [WALL_W-1:0] res_walls_reg, res_walls_next;
    logic              res_done_reg, res_done_next;
    logic              res_clear_reg, res_clear_next;
    logic [COL_OUT_W-1:0] cell_col_reg, cell_col_next;
    logic [ROW_OUT_W-1:0] cell_row_reg, cell_row_next;
    logic              carved_reg, carved_next;
    dir_t              dir_reg, dir_next;
    logic              back_reg, back_next;
    logic [WALL_W-1:0] walls_reg, walls_next;
    logic              done_reg, done_next;

    // cell memory: {visited, walls}
    logic [WALL_W:0]    cell_mem [CELLS];
    logic               cell_we;
    logic [AW-1:0]      cell_waddr, cell_raddr;
    logic [WALL_W:0]    cell_wdata, cell_rdata;

    logic [CW+RW-1:0]   stk_mem [CELLS];
    logic               stk_we;
    logic [AW-1:0]      stk_waddr, stk_raddr;
    logic [CW+RW-1:0]   stk_wdata, stk_rdata;

    logic [AW-1:0]      cur_idx;
    logic [AW-1:0]      nb_addr [4];
    logic [3:0]         in_range, ok;
    logic [BIAS_W-1:0]  weight [4];
    logic [LEN_W-1:0]   len;
    logic [LEN_W:0]     trial;
    logic [LEN_W-1:0]   k;
    logic               found;
    dir_t               sel;
    logic [CW-1:0]      sel_col;
    logic [RW-1:0]      sel_row;
    logic [WALL_W-1:0]  next_walls;
    logic [DW-1:0]      depth_dec;
    logic               out_load;

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rdata <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata <= stk_mem[stk_raddr];
    end

    always_comb
    begin
        cur_idx    = AW'(32'(row_reg) * GRID_WIDTH + 32'(col_reg));
        nb_addr[0] = cur_idx + AW'(1);
        nb_addr[1] = cur_idx - AW'(1);
        nb_addr[2] = cur_idx + AW'(GRID_WIDTH);
        nb_addr[3] = cur_idx - AW'(GRID_WIDTH);
        in_range[0] = col_reg != CW'(GRID_WIDTH - 1);
        in_range[1] = col_reg != '0;
        in_range[2] = row_reg != RW'(GRID_HEIGHT - 1);
        in_range[3] = row_reg != '0;
        ok = in_range & ~nb_vis_reg;
        weight[0] = hbias_reg;
        weight[1] = hbias_reg;
        weight[2] = vbias_reg;
        weight[3] = vbias_reg;
        len = (ok[0] ? LEN_W'(weight[0]) : '0) + (ok[1] ? LEN_W'(weight[1]) : '0)
            + (ok[2] ? LEN_W'(weight[2]) : '0) + (ok[3] ? LEN_W'(weight[3]) : '0);
        trial = {rem_reg, rnd_reg[bit_cnt_reg]};

        // walk the weighted list to the chosen entry
        k     = rem_reg;
        found = 1'b0;
        sel   = DIR_RIGHT;
        for (int d = 0; d < 4; d++)
        begin
            if (!found && ok[d])
            begin
                if (k < LEN_W'(weight[d]))
                begin
                    sel   = dir_t'(2'(d));
                    found = 1'b1;
                end
                else
                begin
                    k = k - LEN_W'(weight[d]);
                end
            end
        end

        sel_col = col_reg;
        sel_row = row_reg;
        case (sel)
            DIR_RIGHT: sel_col = col_reg + CW'(1);
            DIR_LEFT:  sel_col = col_reg - CW'(1);
            DIR_DOWN:  sel_row = row_reg + RW'(1);
            DIR_UP:    sel_row = row_reg - RW'(1);
            default:   sel_col = col_reg;
        endcase
        next_walls = nb_wall_reg[sel] & ~far_bit(sel);
        depth_dec  = depth_reg - DW'(1);
        out_load   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next      = state_reg;
        hbias_next      = hbias_reg;
        vbias_next      = vbias_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        depth_next      = depth_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        rnd_next        = rnd_reg;
        rd_cnt_next     = rd_cnt_reg;
        cur_wall_next   = cur_wall_reg;
        nb_vis_next     = nb_vis_reg;
        nb_wall_next    = nb_wall_reg;
        rem_next        = rem_reg;
        bit_cnt_next    = bit_cnt_reg;
        res_carved_next = res_carved_reg;
        res_dir_next    = res_dir_reg;
        res_back_next   = res_back_reg;
        res_walls_next  = res_walls_reg;
        res_done_next   = res_done_reg;
        res_clear_next  = res_clear_reg;
        cell_col_next   = cell_col_reg;
        cell_row_next   = cell_row_reg;
        carved_next     = carved_reg;
        dir_next        = dir_reg;
        back_next       = back_reg;
        walls_next      = walls_reg;
        done_next       = done_reg;
        in_ready        = 1'b0;
        cell_we         = 1'b0;
        cell_waddr      = cur_idx;
        cell_wdata      = {1'b1, cur_wall_reg};
        cell_raddr      = cur_idx;
        stk_we          = 1'b0;
        stk_waddr       = depth_reg[AW-1:0];
        stk_wdata       = {row_reg, col_reg};
        stk_raddr       = depth_dec[AW-1:0];

        if (cfg_write_en)
        begin
            if (cfg_index == REG_HBIAS)
            begin
                hbias_next = cfg_data;
            end
            else
            begin
                vbias_next = cfg_data;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_cnt_reg;
                cell_wdata = {1'b0, ALL_WALLS};
                if (clr_cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command)
                    begin
                        col_next        = '0;
                        row_next        = '0;
                        depth_next      = '0;
                        res_carved_next = 1'b0;
                        res_dir_next    = DIR_RIGHT;
                        res_back_next   = 1'b0;
                        res_walls_next  = ALL_WALLS;
                        res_done_next   = 1'b0;
                        res_clear_next  = 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        rnd_next    = random_value;
                        rd_cnt_next = '0;
                        state_next  = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // issue one read a cycle, take the previous one's data
                cell_raddr = (rd_cnt_reg == '0) ? cur_idx : nb_addr[2'(rd_cnt_reg - 3'd1)];
                if (rd_cnt_reg == 3'd1)
                begin
                    cur_wall_next = cell_rdata[WALL_W-1:0];
                end
                else if (rd_cnt_reg != '0)
                begin
                    nb_vis_next[2'(rd_cnt_reg - 3'd2)]  = cell_rdata[WALL_W];
                    nb_wall_next[2'(rd_cnt_reg - 3'd2)] = cell_rdata[WALL_W-1:0];
                end
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + 3'd1;
                end
            end
            S_LAST:
            begin
                nb_vis_next[3]  = cell_rdata[WALL_W];
                nb_wall_next[3] = cell_rdata[WALL_W-1:0];
                rem_next        = '0;
                bit_cnt_next    = 4'd15;
                state_next      = S_MOD;
            end
            S_MOD:
            begin
                // restoring remainder, one bit of random_value a cycle
                if (trial >= {1'b0, len})
                begin
                    rem_next = LEN_W'(trial - {1'b0, len});
                end
                else
                begin
                    rem_next = LEN_W'(trial);
                end
                if (bit_cnt_reg == '0)
                begin
                    state_next = S_WCUR;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 4'd1;
                end
            end
            S_WCUR:
            begin
                cell_we = 1'b1;
                if (len != '0)
                begin
                    cell_wdata = {1'b1, cur_wall_reg & ~own_bit(sel)};
                    state_next = S_WNEXT;
                end
                else
                begin
                    cell_wdata = {1'b1, cur_wall_reg};
                    if (depth_reg != '0)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        res_carved_next = 1'b0;
                        res_dir_next    = DIR_RIGHT;
                        res_back_next   = 1'b1;
                        res_walls_next  = cur_wall_reg;
                        res_done_next   = (col_reg == '0) && (row_reg == '0);
                        res_clear_next  = (col_reg == '0) && (row_reg == '0);
                        state_next      = S_OUT;
                    end
                end
            end
            S_WNEXT:
            begin
                cell_we    = 1'b1;
                cell_waddr = nb_addr[sel];
                cell_wdata = {1'b1, next_walls};
                if (depth_reg < DW'(CELLS))
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
                col_next        = sel_col;
                row_next        = sel_row;
                res_carved_next = 1'b1;
                res_dir_next    = sel;
                res_back_next   = 1'b0;
                res_walls_next  = next_walls;
                res_done_next   = (sel_col == '0) && (sel_row == '0);
                res_clear_next  = (sel_col == '0) && (sel_row == '0);
                state_next      = S_OUT;
            end
            S_POP:
            begin
                depth_next = depth_dec;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                col_next   = stk_rdata[CW-1:0];
                row_next   = stk_rdata[CW+RW-1:CW];
                cell_raddr = AW'(32'(stk_rdata[CW+RW-1:CW]) * GRID_WIDTH
                                 + 32'(stk_rdata[CW-1:0]));
                state_next = S_PCAP;
            end
            S_PCAP:
            begin
                res_carved_next = 1'b0;
                res_dir_next    = DIR_RIGHT;
                res_back_next   = 1'b1;
                res_walls_next  = cell_rdata[WALL_W-1:0];
                res_done_next   = (col_reg == '0) && (row_reg == '0);
                res_clear_next  = (col_reg == '0) && (row_reg == '0);
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    cell_col_next  = COL_OUT_W'(col_reg);
                    cell_row_next  = ROW_OUT_W'(row_reg);
                    carved_next    = res_carved_reg;
                    dir_next       = res_dir_reg;
                    back_next      = res_back_reg;
                    walls_next     = res_walls_reg;
                    done_next      = res_done_reg;
                    if (res_clear_reg)
                    begin
                        col_next     = '0;
                        row_next     = '0;
                        depth_next   = '0;
                        clr_cnt_next = '0;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hbias_reg     <= BIAS_W'(1);
            vbias_reg     <= BIAS_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            depth_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hbias_reg     <= hbias_next;
            vbias_reg     <= vbias_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            depth_reg     <= depth_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg        <= rnd_next;
        rd_cnt_reg     <= rd_cnt_next;
        cur_wall_reg   <= cur_wall_next;
        nb_vis_reg     <= nb_vis_next;
        nb_wall_reg    <= nb_wall_next;
        rem_reg        <= rem_next;
        bit_cnt_reg    <= bit_cnt_next;
        res_carved_reg <= res_carved_next;
        res_dir_reg    <= res_dir_next;
        res_back_reg   <= res_back_next;
        res_walls_reg  <= res_walls_next;
        res_done_reg   <= res_done_next;
        res_clear_reg  <= res_clear_next;
        cell_col_reg   <= cell_col_next;
        cell_row_reg   <= cell_row_next;
        carved_reg     <= carved_next;
        dir_reg        <= dir_next;
        back_reg       <= back_next;
        walls_reg      <= walls_next;
        done_reg       <= done_next;
    end

    assign out_valid       = out_valid_reg;
    assign cell_col        = cell_col_reg;
    assign cell_row        = cell_row_reg;
    assign carved          = carved_reg;
    assign carve_direction = dir_reg;
    assign backtracking    = back_reg;
    assign cell_walls      = walls_reg;
    assign maze_done       = done_reg;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(CELLS))
        else $error("trail depth beyond grid size");

    a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && (clr_cnt_reg != AW'(CELLS - 1)) |=> state_reg == S_CLEAR)
        else $error("clearing pass left early");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && out_load && res_done_reg
        |=> (state_reg == S_CLEAR) && (clr_cnt_reg == '0))
        else $error("finished maze not followed by a clear");

    a_carve_xor_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(carved && backtracking))
        else $error("carve and backtrack in the same word");
`endif

endmodule
